/* hw/rtl/cia_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_pkg: shared types and codes for the checked int32 ALU
// Opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned StW   = 3;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5,
    OP_NEG = 3'd6,
    OP_NOP = 3'd7
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK      = 3'd0,
    ST_OVER    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_NEGEXP  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PMUL,
    S_PSQ,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

/* hw/rtl/checked_int32_alu_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checked_int32_alu_core: 32-bit signed ALU with checked results
// add/sub/mul/neg are computed in S_IDLE; div/mod iterate in S_DIV (one
// restoring quotient bit a cycle); pow alternates S_PMUL and S_PSQ, every
// checked multiply going through the single shared 32x32 multiplier.
// One beat in flight; the next input is taken once the result is taken.
// Reset (async, active low) clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module checked_int32_alu_core
  import cia_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    req_valid_i,
  output logic                         req_stall_o,
  input  wire logic [OpW-1:0]          req_type_i,
  input  wire logic signed [DataW-1:0] operand_a_i,
  input  wire logic signed [DataW-1:0] operand_b_i,
  output logic                         res_valid_o,
  input  wire logic                    res_stall_i,
  output logic signed [DataW-1:0]      value_o,
  output logic [StW-1:0]               status_o
);

  localparam logic [DataW-1:0] MinV = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] One  = {{(DataW-1){1'b0}}, 1'b1};
  localparam int unsigned CntW = $clog2(DataW + 1);

  state_e state_q, state_d;
  logic                  out_v_q, out_v_d;
  logic [DataW-1:0]      val_q, val_d;
  status_e               st_q, st_d;
  op_e                   op_q, op_d;
  logic [DataW-1:0]      a_q, a_d;     // divisor magnitude / pow base
  logic [DataW-1:0]      b_q, b_d;     // dividend shift reg / pow exponent
  logic [DataW-1:0]      acc_q, acc_d; // remainder / pow accumulator
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  qneg_q, qneg_d, rneg_q, rneg_d;

  logic signed [DataW-1:0]   m_x, m_y;
  logic signed [2*DataW-1:0] prod;
  status_e                   m_st;
  logic [DataW:0]            rem_sh, rem_sub;
  logic signed [DataW:0]     sum_ext;
  logic [DataW-1:0]          amag, bmag;
  op_e                       op_in;

  assign prod = m_x * m_y;

  always_comb begin
    if (prod > $signed({{(DataW+1){1'b0}}, {(DataW-1){1'b1}}})) begin
      m_st = ST_OVER;
    end else if (prod < $signed({{(DataW+1){1'b1}}, {(DataW-1){1'b0}}})) begin
      m_st = ST_UNDER;
    end else begin
      m_st = ST_OK;
    end
  end

  assign rem_sh  = {acc_q, b_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, a_q};
  assign amag    = operand_a_i[DataW-1] ? (~operand_a_i + One) : operand_a_i;
  assign bmag    = operand_b_i[DataW-1] ? (~operand_b_i + One) : operand_b_i;
  assign op_in   = op_e'(req_type_i);

  always_comb begin
    state_d = state_q; out_v_d = out_v_q; val_d = val_q; st_d = st_q;
    op_d = op_q; a_d = a_q; b_d = b_q; acc_d = acc_q; cnt_d = cnt_q;
    qneg_d = qneg_q; rneg_d = rneg_q;
    m_x = operand_a_i; m_y = operand_b_i;
    sum_ext = '0;
    req_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d = op_in; st_d = ST_OK; val_d = '0; state_d = S_DONE;
          case (op_in)
            OP_ADD, OP_SUB: begin
              sum_ext = (op_in == OP_ADD) ?
                {operand_a_i[DataW-1], operand_a_i} + {operand_b_i[DataW-1], operand_b_i} :
                {operand_a_i[DataW-1], operand_a_i} - {operand_b_i[DataW-1], operand_b_i};
              if (sum_ext[DataW] != sum_ext[DataW-1]) begin
                st_d = sum_ext[DataW] ? ST_UNDER : ST_OVER;
              end else begin
                val_d = sum_ext[DataW-1:0];
              end
            end
            OP_MUL: begin
              st_d = m_st;
              if (m_st == ST_OK) val_d = prod[DataW-1:0];
            end
            OP_DIV, OP_MOD: begin
              if (operand_b_i == '0) begin
                st_d = ST_DIVZERO;
              end else if (operand_a_i == MinV && operand_b_i == '1) begin
                st_d = ST_OVER;
              end else begin
                a_d = bmag; b_d = amag; acc_d = '0; cnt_d = CntW'(DataW);
                qneg_d = operand_a_i[DataW-1] ^ operand_b_i[DataW-1];
                rneg_d = operand_a_i[DataW-1];
                state_d = S_DIV;
              end
            end
            OP_POW: begin
              if (operand_b_i[DataW-1]) begin
                st_d = ST_NEGEXP;
              end else begin
                a_d = operand_a_i; b_d = operand_b_i; acc_d = One;
                state_d = S_PMUL;
              end
            end
            OP_NEG: begin
              if (operand_a_i == MinV) st_d = ST_OVER;
              else val_d = ~operand_a_i + One;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (!rem_sub[DataW]) begin
          acc_d = rem_sub[DataW-1:0];
          b_d = {b_q[DataW-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[DataW-1:0];
          b_d = {b_q[DataW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) state_d = S_DONE;
        if (cnt_q == CntW'(1)) begin
          if (op_q == OP_DIV) val_d = qneg_q ? (~b_d + One) : b_d;
          else val_d = rneg_q ? (~acc_d + One) : acc_d;
        end
      end
      S_PMUL: begin
        m_x = acc_q; m_y = a_q;
        if (b_q == '0) begin
          val_d = acc_q; state_d = S_DONE;
        end else if (b_q[0]) begin
          if (m_st != ST_OK) begin
            st_d = m_st; state_d = S_DONE;
          end else begin
            acc_d = prod[DataW-1:0]; state_d = S_PSQ;
          end
        end else begin
          state_d = S_PSQ;
        end
      end
      S_PSQ: begin
        m_x = a_q; m_y = a_q;
        b_d = b_q >> 1;
        if (b_d == '0) begin
          val_d = acc_q; state_d = S_DONE;
        end else if (m_st != ST_OK) begin
          st_d = m_st; state_d = S_DONE;
        end else begin
          a_d = prod[DataW-1:0]; state_d = S_PMUL;
        end
      end
      S_DONE: begin
        if (!out_v_q) begin
          out_v_d = 1'b1;
          if (st_q != ST_OK) val_d = '0;
        end else if (!res_stall_i) begin
          out_v_d = 1'b0; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; st_q <= st_d; op_q <= op_d; a_q <= a_d; b_q <= b_d;
    acc_q <= acc_d; cnt_q <= cnt_d; qneg_q <= qneg_d; rneg_q <= rneg_d;
  end

  assign res_valid_o = out_v_q;
  assign value_o     = val_q;
  assign status_o    = st_q;

  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> state_q == S_DONE) else $error("valid outside done");
  a_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o != ST_OK) |-> value_o == '0)
    else $error("nonzero value with error status");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> req_stall_o) else $error("input open while result held");

endmodule
`default_nettype wire
